FILE: rtl/tlbp_pkg.sv
// Shared types, constants and configuration register codes for the
// two-level branch predictor with target buffer. No dependencies.
package tlbp_pkg;

  localparam int BTB_ENTRIES_DEF   = 32;
  localparam int HISTORY_MAX_DEF   = 8;
  localparam int TABLE_ENTRIES_DEF = 256;

  localparam int PC_W      = 32;
  localparam int TAG_W     = 30;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 5;
  localparam int IDX_MAX   = 5;

  localparam logic [1:0] CTR_WNT = 2'd1;
  localparam logic [PC_W-1:0] STAT_MAX = 32'hffff_ffff;

  localparam logic [CFG_IDX_W-1:0] REG_BTB_BITS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_BITS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLOB_HIST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GLOB_TBL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE     = 3'd5;

  localparam logic [1:0] SHARE_PLAIN = 2'd0;
  localparam logic [1:0] SHARE_LOW   = 2'd1;
  localparam logic [1:0] SHARE_HIGH  = 2'd2;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  typedef struct packed {
    logic [2:0] btb_bits;
    logic [3:0] hist_bits;
    logic [4:0] tag_bits;
    logic       tag_on;
    logic       glob_hist;
    logic       glob_tbl;
    logic [1:0] share;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_ENTRY,
    ST_RD_CTR,
    ST_WRITE,
    ST_SWEEP
  } state_t;

endpackage

FILE: rtl/tlbp_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module tlbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/tlbp_cfg.sv
// Configuration registers and their clamped working values.
// Depends on tlbp_pkg.
module tlbp_cfg
  import tlbp_pkg::*;
#(
  parameter int HISTORY_MAX = HISTORY_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 we,
  input  logic [CFG_IDX_W-1:0] idx,
  input  logic [CFG_DAT_W-1:0] data,
  output cfg_t                 cfg
);

  logic [2:0] btb_r;
  logic [3:0] hist_r;
  logic [4:0] tag_r;
  logic       gh_r;
  logic       gt_r;
  logic [1:0] share_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btb_r   <= 3'd5;
      hist_r  <= 4'd8;
      tag_r   <= 5'd0;
      gh_r    <= 1'b0;
      gt_r    <= 1'b0;
      share_r <= 2'd0;
    end else if (we) begin
      unique case (idx)
        REG_BTB_BITS:  btb_r   <= data[2:0];
        REG_HIST_BITS: hist_r  <= data[3:0];
        REG_TAG_BITS:  tag_r   <= data;
        REG_GLOB_HIST: gh_r    <= data[0];
        REG_GLOB_TBL:  gt_r    <= data[0];
        REG_SHARE:     share_r <= data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.btb_bits  = (btb_r > 3'(IDX_MAX)) ? 3'(IDX_MAX) : btb_r;
    cfg.hist_bits = (hist_r > 4'(HISTORY_MAX)) ? 4'(HISTORY_MAX) : hist_r;
    cfg.tag_bits  = (tag_r > 5'(TAG_W)) ? 5'(TAG_W) : tag_r;
    cfg.tag_on    = (tag_r != 5'd0);
    cfg.glob_hist = gh_r;
    cfg.glob_tbl  = gt_r;
    cfg.share     = (share_r == 2'd3) ? SHARE_PLAIN : share_r;
  end

endmodule

FILE: rtl/two_level_branch_predictor_btb_top.sv
// Top level: sequencer, entry and counter memories, statistics.
// Depends on tlbp_pkg, tlbp_ram and tlbp_cfg.
//
// One item at a time. An item passes through entry read, counter read and
// write back before its result. The two dependent reads of the single-port
// entry and counter memories set this order. The next item is accepted in the
// cycle the result appears, if the receiver takes that result at once. A
// predict that misses the tag gives its result from the counter read, without
// write back. With per-entry tables it then sweeps that entry's table before
// the next item. After reset the counter memory is filled with weakly-not-taken,
// with in_ready low.
// Configuration writes are taken at any time.
module two_level_branch_predictor_btb_top
  import tlbp_pkg::*;
#(
  parameter int BTB_ENTRIES   = BTB_ENTRIES_DEF,
  parameter int HISTORY_MAX   = HISTORY_MAX_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic [PC_W-1:0]      in_pc,
  input  logic [PC_W-1:0]      in_target_pc,
  input  logic                 in_taken,
  input  logic [PC_W-1:0]      in_predicted_target,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_predict_taken,
  output logic [PC_W-1:0]      out_next_pc,
  output logic                 out_flushed,
  output logic [PC_W-1:0]      out_branch_count,
  output logic [PC_W-1:0]      out_flush_count
);

  localparam int BIDX_W    = (BTB_ENTRIES > 1) ? $clog2(BTB_ENTRIES) : 1;
  localparam int TIDX_W    = $clog2(TABLE_ENTRIES);
  localparam int CTR_DEPTH = BTB_ENTRIES * TABLE_ENTRIES;
  localparam int CADDR_W   = $clog2(CTR_DEPTH);
  localparam int MOD_W     = HISTORY_MAX + TIDX_W + 1;
  localparam int ENT_W     = TAG_W + HISTORY_MAX + PC_W;

  cfg_t cfg;

  tlbp_cfg #(.HISTORY_MAX(HISTORY_MAX)) u_cfg (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (cfg_valid),
    .idx  (cfg_index),
    .data (cfg_data),
    .cfg  (cfg)
  );

  assign cfg_ready = 1'b1;

  state_t state_r, state_nxt;

  logic                   op_r, tk_r;
  logic [PC_W-1:0]        pc_r, tgt_r, pdst_r;
  logic [HISTORY_MAX-1:0] ent_hist_r, ghist_r;
  logic [PC_W-1:0]        ent_tgt_r;
  logic [CADDR_W-1:0]     pos_r, sweep_r, base_r;
  logic [BTB_ENTRIES-1:0] ent_vld_r;
  logic                   last_r;
  logic [PC_W-1:0]        pred_cnt_r, flush_cnt_r;
  logic                   out_valid_r, out_pt_r, out_fl_r;
  logic [PC_W-1:0]        out_npc_r, out_bc_r, out_fc_r;

  // entry index, tag and history mask
  logic [4:0]             bmask, idx5;
  logic [BIDX_W-1:0]      ent_idx;
  logic [TAG_W-1:0]       tmask, pc_tag;
  logic [HISTORY_MAX-1:0] hmask;

  always_comb begin
    bmask   = 5'((6'd1 << cfg.btb_bits) - 6'd1);
    idx5    = pc_r[6:2] & bmask;
    ent_idx = BIDX_W'({1'b0, idx5} % 6'(BTB_ENTRIES));
    tmask   = TAG_W'((31'd1 << cfg.tag_bits) - 31'd1);
    pc_tag  = pc_r[2 +: TAG_W] & tmask;
    hmask   = HISTORY_MAX'(((HISTORY_MAX+1)'(1) << cfg.hist_bits) - (HISTORY_MAX+1)'(1));
  end

  // entry memory
  logic                   ent_we;
  logic [ENT_W-1:0]       ent_wdata, ent_rdata;
  logic [TAG_W-1:0]       rd_tag;
  logic [HISTORY_MAX-1:0] rd_hist;
  logic [PC_W-1:0]        rd_tgt;

  tlbp_ram #(.WIDTH(ENT_W), .DEPTH(BTB_ENTRIES), .AW(BIDX_W)) u_ent_ram (
    .clk  (clk),
    .we   (ent_we),
    .addr (ent_idx),
    .wdata(ent_wdata),
    .rdata(ent_rdata)
  );

  always_comb begin
    if (ent_vld_r[ent_idx]) begin
      {rd_tag, rd_hist, rd_tgt} = ent_rdata;
    end else begin
      rd_tag  = '0;
      rd_hist = '0;
      rd_tgt  = '0;
    end
  end

  // counter position from the just-read entry
  logic                   miss;
  logic [HISTORY_MAX-1:0] ti;
  logic [TIDX_W-1:0]      tidx;
  logic [CADDR_W-1:0]     tbl_base, pos;

  always_comb begin
    miss = cfg.tag_on && (pc_tag != rd_tag);
    ti   = (cfg.glob_hist ? ghist_r : rd_hist) & hmask;
    if (cfg.glob_tbl && cfg.share == SHARE_LOW) begin
      ti = ti ^ (pc_r[2 +: HISTORY_MAX] & hmask);
    end else if (cfg.glob_tbl && cfg.share == SHARE_HIGH) begin
      ti = ti ^ (pc_r[16 +: HISTORY_MAX] & hmask);
    end
    tidx     = TIDX_W'(MOD_W'(ti) % MOD_W'(TABLE_ENTRIES));
    tbl_base = CADDR_W'(ent_idx) * CADDR_W'(TABLE_ENTRIES);
    pos      = (cfg.glob_tbl ? '0 : tbl_base) + CADDR_W'(tidx);
  end

  // counter memory
  logic               ctr_we;
  logic [CADDR_W-1:0] ctr_addr;
  logic [1:0]         ctr_wdata, ctr_rdata, ctr_new;

  tlbp_ram #(.WIDTH(2), .DEPTH(CTR_DEPTH), .AW(CADDR_W)) u_ctr_ram (
    .clk  (clk),
    .we   (ctr_we),
    .addr (ctr_addr),
    .wdata(ctr_wdata),
    .rdata(ctr_rdata)
  );

  always_comb begin
    if (tk_r) begin
      ctr_new = (ctr_rdata == 2'd3) ? ctr_rdata : ctr_rdata + 2'd1;
    end else begin
      ctr_new = (ctr_rdata == 2'd0) ? ctr_rdata : ctr_rdata - 2'd1;
    end
  end

  logic                   flush;
  logic [HISTORY_MAX-1:0] hist_sh, new_ent_hist;

  always_comb begin
    flush        = (tk_r ^ last_r) | (tk_r & (pdst_r != tgt_r));
    hist_sh      = ((cfg.glob_hist ? ghist_r : ent_hist_r) << 1) | HISTORY_MAX'(tk_r);
    new_ent_hist = cfg.glob_hist ? ent_hist_r : (hist_sh & hmask);
  end

  // sequencer
  logic in_acc, rel_out;

  assign rel_out  = out_valid_r && out_ready;
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ent_we    = 1'b0;
    ent_wdata = '0;
    ctr_we    = 1'b0;
    ctr_addr  = pos_r;
    ctr_wdata = CTR_WNT;
    unique case (state_r)
      ST_CLEAR: begin
        ctr_we   = 1'b1;
        ctr_addr = sweep_r;
        if (sweep_r == CADDR_W'(CTR_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RD_ENTRY;
        end
      end
      ST_RD_ENTRY: begin
        state_nxt = ST_RD_CTR;
      end
      ST_RD_CTR: begin
        ctr_addr = pos;
        if (op_r == OP_PREDICT && miss) begin
          ent_we    = 1'b1;
          state_nxt = cfg.glob_tbl ? ST_IDLE : ST_SWEEP;
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (op_r == OP_UPDATE) begin
          ctr_we    = 1'b1;
          ctr_wdata = ctr_new;
          ent_we    = 1'b1;
          ent_wdata = {pc_tag, new_ent_hist, tgt_r};
        end
        state_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        ctr_we   = 1'b1;
        ctr_addr = base_r + sweep_r;
        if (sweep_r == CADDR_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      ent_vld_r   <= '0;
      ghist_r     <= '0;
      last_r      <= 1'b0;
      pred_cnt_r  <= '0;
      flush_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rel_out) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_CLEAR || state_r == ST_SWEEP) begin
        sweep_r <= (state_nxt == ST_IDLE) ? '0 : sweep_r + CADDR_W'(1);
      end
      if (ent_we) begin
        ent_vld_r[ent_idx] <= 1'b1;
      end
      if (state_r == ST_RD_CTR && op_r == OP_PREDICT && miss) begin
        pred_cnt_r  <= (pred_cnt_r == STAT_MAX) ? pred_cnt_r : pred_cnt_r + 32'd1;
        last_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end
      if (state_r == ST_WRITE) begin
        out_valid_r <= 1'b1;
        if (op_r == OP_PREDICT) begin
          pred_cnt_r <= (pred_cnt_r == STAT_MAX) ? pred_cnt_r : pred_cnt_r + 32'd1;
          last_r     <= ctr_rdata[1];
        end else begin
          if (flush && flush_cnt_r != STAT_MAX) begin
            flush_cnt_r <= flush_cnt_r + 32'd1;
          end
          if (cfg.glob_hist) begin
            ghist_r <= hist_sh & hmask;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_opcode;
      pc_r   <= in_pc;
      tgt_r  <= in_target_pc;
      tk_r   <= in_taken;
      pdst_r <= in_predicted_target;
    end
    if (state_r == ST_RD_CTR) begin
      ent_hist_r <= rd_hist;
      ent_tgt_r  <= rd_tgt;
      pos_r      <= pos;
      base_r     <= tbl_base;
      if (op_r == OP_PREDICT && miss) begin
        out_pt_r  <= 1'b0;
        out_npc_r <= pc_r + 32'd4;
        out_fl_r  <= 1'b0;
        out_bc_r  <= (pred_cnt_r == STAT_MAX) ? pred_cnt_r : pred_cnt_r + 32'd1;
        out_fc_r  <= flush_cnt_r;
      end
    end
    if (state_r == ST_WRITE) begin
      if (op_r == OP_PREDICT) begin
        out_pt_r  <= ctr_rdata[1];
        out_npc_r <= ctr_rdata[1] ? ent_tgt_r : pc_r + 32'd4;
        out_fl_r  <= 1'b0;
        out_bc_r  <= (pred_cnt_r == STAT_MAX) ? pred_cnt_r : pred_cnt_r + 32'd1;
        out_fc_r  <= flush_cnt_r;
      end else begin
        out_pt_r  <= 1'b0;
        out_npc_r <= '0;
        out_fl_r  <= flush;
        out_bc_r  <= pred_cnt_r;
        out_fc_r  <= (flush && flush_cnt_r != STAT_MAX) ? flush_cnt_r + 32'd1 : flush_cnt_r;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_predict_taken = out_pt_r;
  assign out_next_pc       = out_npc_r;
  assign out_flushed       = out_fl_r;
  assign out_branch_count  = out_bc_r;
  assign out_flush_count   = out_fc_r;

endmodule

FILE: test/two_level_branch_predictor_btb_top_test.sv
// Testbench for two_level_branch_predictor_btb_top: directed table, then random
// predict/update sequences over several register settings, checked against a
// behavioral predictor. Depends on tlbp_pkg and the RTL top level.
module two_level_branch_predictor_btb_top_test
  import tlbp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES   = BTB_ENTRIES_DEF;
  localparam int TBL_SIZE  = TABLE_ENTRIES_DEF;
  localparam int HIST_MAX  = HISTORY_MAX_DEF;
  localparam int LIMIT     = 600000;
  localparam int SETTLE    = 300;
  localparam int N_RANDOM  = 50;
  localparam int N_PHASES  = 5;

  typedef struct packed {
    logic            taken;
    logic [PC_W-1:0] next_pc;
    logic            flushed;
    logic [PC_W-1:0] branches;
    logic [PC_W-1:0] flushes;
  } branch_result_t;

  typedef struct packed {
    logic            op;
    logic [PC_W-1:0] pc;
    logic [PC_W-1:0] target;
    logic            taken;
    logic [PC_W-1:0] pred_target;
    logic            typed;
    branch_result_t  want;
  } branch_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic in_valid, in_ready, in_opcode, in_taken;
  logic [PC_W-1:0] in_pc, in_target_pc, in_predicted_target;
  logic out_valid, out_ready, out_predict_taken, out_flushed;
  logic [PC_W-1:0] out_next_pc, out_branch_count, out_flush_count;

  two_level_branch_predictor_btb_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode), .in_pc(in_pc),
    .in_target_pc(in_target_pc), .in_taken(in_taken),
    .in_predicted_target(in_predicted_target),
    .out_valid(out_valid), .out_ready(out_ready), .out_predict_taken(out_predict_taken),
    .out_next_pc(out_next_pc), .out_flushed(out_flushed),
    .out_branch_count(out_branch_count), .out_flush_count(out_flush_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [2:0]  m_btb_bits;
  logic [3:0]  m_hist_bits;
  logic [4:0]  m_tag_bits;
  logic        m_glob_hist, m_glob_tbl;
  logic [1:0]  m_share;
  logic [29:0] m_tags [ENTRIES];
  logic [7:0]  m_hist [ENTRIES];
  logic [31:0] m_targets [ENTRIES];
  logic [7:0]  m_ghist;
  logic [1:0]  m_ctr [ENTRIES*TBL_SIZE];
  logic        m_last;
  logic [31:0] m_branches, m_flushes;

  branch_result_t pending_results [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  function automatic logic [31:0] hist_mask();
    int h;
    h = (m_hist_bits > HIST_MAX) ? HIST_MAX : m_hist_bits;
    return (32'd1 << h) - 32'd1;
  endfunction

  function automatic logic [31:0] tag_field(logic [31:0] pc);
    int t;
    t = (m_tag_bits > 30) ? 30 : m_tag_bits;
    return (pc >> 2) & ((32'd1 << t) - 32'd1);
  endfunction

  function automatic int entry_index(logic [31:0] pc);
    int b;
    b = (m_btb_bits > IDX_MAX) ? IDX_MAX : m_btb_bits;
    return ((pc >> 2) & ((32'd1 << b) - 32'd1)) % ENTRIES;
  endfunction

  function automatic int counter_index(logic [31:0] pc, int e);
    logic [31:0] hm, ti;
    hm = hist_mask();
    ti = (m_glob_hist ? {24'd0, m_ghist} : {24'd0, m_hist[e]}) & hm;
    if (m_glob_tbl && m_share == SHARE_LOW) ti ^= (pc >> 2) & hm;
    else if (m_glob_tbl && m_share == SHARE_HIGH) ti ^= (pc >> 16) & hm;
    ti = ti % TBL_SIZE;
    return (m_glob_tbl ? 0 : e) * TBL_SIZE + int'(ti);
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == STAT_MAX) ? v : v + 32'd1;
  endfunction

  task automatic reset_predictor();
    m_btb_bits = 3'd5; m_hist_bits = 4'd8; m_tag_bits = 5'd0;
    m_glob_hist = 1'b0; m_glob_tbl = 1'b0; m_share = SHARE_PLAIN;
    foreach (m_tags[i]) begin
      m_tags[i] = '0; m_hist[i] = '0; m_targets[i] = '0;
    end
    foreach (m_ctr[i]) m_ctr[i] = CTR_WNT;
    m_ghist = '0; m_last = 1'b0; m_branches = '0; m_flushes = '0;
  endtask

  function automatic branch_result_t predict_branch(logic op, logic [31:0] pc,
                                                    logic [31:0] tgt, logic tk,
                                                    logic [31:0] pdst);
    branch_result_t r;
    int e, pos;
    logic [1:0] c;
    logic [31:0] hm;
    r = '0;
    e = entry_index(pc);
    hm = hist_mask();
    if (op == OP_PREDICT) begin
      m_branches = sat_inc(m_branches);
      r.next_pc = pc + 32'd4;
      if (m_tag_bits != 0 && tag_field(pc) != {2'b0, m_tags[e]}) begin
        m_tags[e] = '0; m_hist[e] = '0; m_targets[e] = '0;
        if (!m_glob_tbl)
          for (int i = 0; i < TBL_SIZE; i++) m_ctr[e*TBL_SIZE + i] = CTR_WNT;
      end else if (m_ctr[counter_index(pc, e)] >= 2'd2) begin
        r.taken = 1'b1;
        r.next_pc = m_targets[e];
      end
      m_last = r.taken;
    end else begin
      if ((tk ^ m_last) || (tk && pdst != tgt)) begin
        r.flushed = 1'b1;
        m_flushes = sat_inc(m_flushes);
      end
      m_tags[e] = 30'(tag_field(pc));
      pos = counter_index(pc, e);
      c = m_ctr[pos];
      if (tk) begin
        if (c < 2'd3) c++;
      end else begin
        if (c > 2'd0) c--;
      end
      m_ctr[pos] = c;
      if (m_glob_hist) m_ghist = 8'(((m_ghist << 1) + tk) & hm);
      else m_hist[e] = 8'(((m_hist[e] << 1) + tk) & hm);
      m_targets[e] = tgt;
    end
    r.branches = m_branches;
    r.flushes = m_flushes;
    return r;
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BTB_BITS:  m_btb_bits = val[2:0];
      REG_HIST_BITS: m_hist_bits = val[3:0];
      REG_TAG_BITS:  m_tag_bits = val[4:0];
      REG_GLOB_HIST: m_glob_hist = val[0];
      REG_GLOB_TBL:  m_glob_tbl = val[0];
      REG_SHARE:     m_share = val[1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(int b, int h, int t, int gh, int gt, int sh);
    cfg_write(REG_BTB_BITS, CFG_DAT_W'(b));
    cfg_write(REG_HIST_BITS, CFG_DAT_W'(h));
    cfg_write(REG_TAG_BITS, CFG_DAT_W'(t));
    cfg_write(REG_GLOB_HIST, CFG_DAT_W'(gh));
    cfg_write(REG_GLOB_TBL, CFG_DAT_W'(gt));
    cfg_write(REG_SHARE, CFG_DAT_W'(sh));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_item(logic op, logic [31:0] pc, logic [31:0] tgt, logic tk,
                           logic [31:0] pdst, logic typed, branch_result_t want);
    branch_result_t r;
    while (!calm && $urandom_range(99) < 33) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_pc <= pc;
    in_target_pc <= tgt;
    in_taken <= tk;
    in_predicted_target <= pdst;
    do @(posedge clk); while (!in_ready);
    r = predict_branch(op, pc, tgt, tk, pdst);
    pending_results.push_back(typed ? want : r);
    items_sent++;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    branch_result_t w;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        w = pending_results.pop_front();
        check_field("predict_taken", 32'(w.taken), 32'(out_predict_taken));
        check_field("next_pc", w.next_pc, out_next_pc);
        check_field("flushed", 32'(w.flushed), 32'(out_flushed));
        check_field("branch_count", w.branches, out_branch_count);
        check_field("flush_count", w.flushes, out_flush_count);
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (SETTLE) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 33);
      end
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    branch_row_t rows [$];
    logic [31:0] pool [8];
    logic [31:0] pc, tgt, pdst;
    logic tk;
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_opcode = OP_PREDICT; in_pc = '0; in_target_pc = '0;
    in_taken = 1'b0; in_predicted_target = '0;
    reset_predictor();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    rows = '{
      '{OP_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0, 1'b1, '{1'b0, 32'h4, 1'b0, 32'd1, 32'd0}},
      '{OP_UPDATE, 32'h0, 32'h100, 1'b1, 32'h0, 1'b1, '{1'b0, 32'h0, 1'b1, 32'd1, 32'd1}},
      '{OP_PREDICT, 32'hffff_fffc, 32'h0, 1'b0, 32'h0, 1'b1,
        '{1'b0, 32'h0, 1'b0, 32'd2, 32'd1}},
      '{OP_UPDATE, 32'h0, 32'h100, 1'b1, 32'h100, 1'b0, '0},
      '{OP_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, '0},
      '{OP_UPDATE, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'hffff_ffff, 1'b0, '0},
      '{OP_PREDICT, 32'hffff_ffff, 32'h0, 1'b1, 32'hffff_ffff, 1'b0, '0},
      '{OP_UPDATE, 32'h0, 32'h0, 1'b1, 32'hffff_ffff, 1'b0, '0},
      '{OP_PREDICT, 32'h0, 32'hffff_ffff, 1'b0, 32'h0, 1'b0, '0},
      '{OP_UPDATE, 32'h0, 32'hdead_beef, 1'b1, 32'hdead_beef, 1'b0, '0},
      '{OP_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, '0},
      '{OP_UPDATE, 32'h0, 32'hdead_beef, 1'b0, 32'h0, 1'b0, '0},
      '{OP_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, '0},
      '{OP_UPDATE, 32'h7c, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0, '0},
      '{OP_UPDATE, 32'h7c, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0, '0},
      '{OP_PREDICT, 32'h7c, 32'h0, 1'b0, 32'h0, 1'b0, '0}
    };
    foreach (rows[i])
      send_item(rows[i].op, rows[i].pc, rows[i].target, rows[i].taken,
                rows[i].pred_target, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      @(negedge clk);
      in_valid <= 1'b0;
      drain();
      case (ph)
        0: apply_setting(5, 8, 0, 0, 0, SHARE_PLAIN);
        1: apply_setting(0, 1, 30, 1, 1, SHARE_LOW);
        2: apply_setting(5, 8, 3, 0, 1, SHARE_HIGH);
        3: apply_setting(3, 0, 31, 1, 0, 3);
        default: apply_setting(7, 15, 2, 0, 0, SHARE_PLAIN);
      endcase
      for (int k = 0; k < 8; k++) begin
        pool[k] = $urandom();
        if (k >= 4) pool[k] = {pool[k-4][31:8] ^ 24'($urandom()), pool[k-4][7:0]};
      end
      for (int n = 0; n < N_RANDOM; n++) begin
        calm = (ph == 0 && n >= 10 && n < 40);
        if (ph == 1 && n == 20) hold_req = 1'b1;
        pc = pool[$urandom_range(7)];
        tgt = $urandom();
        tk = 1'($urandom_range(1));
        if ($urandom_range(9) == 0) begin
          send_item(1'($urandom_range(1)), $urandom(), tgt, tk, $urandom(), 1'b0, '0);
        end else begin
          send_item(OP_PREDICT, pc, $urandom(), 1'($urandom_range(1)), $urandom(), 1'b0, '0);
          pdst = ($urandom_range(3) == 0) ? $urandom() : tgt;
          send_item(OP_UPDATE, pc, tgt, tk, pdst, 1'b0, '0);
        end
      end
      calm = 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b0;
    drain();
    $display("Ran %0d items over %0d register settings, %0d results checked.",
             items_sent, N_PHASES + 1, results_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
